[hw/rtl/rtcs_pkg.sv]
// ----------------------------------------------------------------------------
// rtcs_pkg
// Shared types and constants for the clock-chip write/poll sequencer.
// ----------------------------------------------------------------------------
package rtcs_pkg;

    localparam int NUM_TIME  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 4;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SEND       = 3'd1,
        ACT_STOP_START = 3'd2,
        ACT_RESTART    = 3'd3,
        ACT_RX_ACK     = 3'd4,
        ACT_RX_NACK    = 3'd5
    } t_action;

    localparam logic OP_EVENT  = 1'b0;
    localparam logic OP_RELOAD = 1'b1;

    // bus controller status codes
    localparam t_byte ST_START      = 8'h08;
    localparam t_byte ST_RSTART     = 8'h10;
    localparam t_byte ST_SLA_W_ACK  = 8'h18;
    localparam t_byte ST_SLA_W_NACK = 8'h20;
    localparam t_byte ST_DATA_ACK   = 8'h28;
    localparam t_byte ST_DATA_NACK  = 8'h30;
    localparam t_byte ST_SLA_R_ACK  = 8'h40;
    localparam t_byte ST_SLA_R_NACK = 8'h48;
    localparam t_byte ST_RX_ACK     = 8'h50;
    localparam t_byte ST_RX_NACK    = 8'h58;

    localparam t_byte DEV_ADDR  = 8'hD0;
    localparam t_byte PTR_BYTE  = 8'h00;
    localparam t_byte CTRL_BYTE = 8'h10;

    // write-pass and read-pass byte positions
    localparam logic [IDX_W-1:0] IDX_CTRL    = 4'd7;
    localparam logic [IDX_W-1:0] IDX_STOP    = 4'd8;
    localparam logic [IDX_W-1:0] IDX_LAST_RX = 4'd5;
    localparam int               TIME_YEAR   = 6;

    localparam t_byte SET_RESET [NUM_TIME] = '{8'd0, 8'd0, 8'd16, 8'd7, 8'd22, 8'd6, 8'd19};

endpackage

[hw/rtl/rtcs_cmd_if.sv]
// ----------------------------------------------------------------------------
// rtcs_cmd_if
// Command channel: bus status events and reload requests.
// ----------------------------------------------------------------------------
interface rtcs_cmd_if;
    logic                valid;
    logic                ready;
    logic                opcode;
    rtcs_pkg::t_byte     status_code;
    rtcs_pkg::t_byte     rx_byte;

    modport source (output valid, output opcode, output status_code, output rx_byte,
                    input ready);
    modport sink   (input valid, input opcode, input status_code, input rx_byte,
                    output ready);
endinterface

[hw/rtl/rtcs_res_if.sv]
// ----------------------------------------------------------------------------
// rtcs_res_if
// Result channel: next bus action plus the held time bytes.
// ----------------------------------------------------------------------------
interface rtcs_res_if;
    logic            valid;
    logic            ready;
    logic [2:0]      action;
    rtcs_pkg::t_byte tx_byte;
    logic            snapshot_valid;
    rtcs_pkg::t_byte out_seconds;
    rtcs_pkg::t_byte out_minutes;
    rtcs_pkg::t_byte out_hours;
    rtcs_pkg::t_byte out_weekday;
    rtcs_pkg::t_byte out_date;
    rtcs_pkg::t_byte out_month;
    rtcs_pkg::t_byte out_year;

    modport source (output valid, output action, output tx_byte, output snapshot_valid,
                    output out_seconds, output out_minutes, output out_hours,
                    output out_weekday, output out_date, output out_month, output out_year,
                    input ready);
    modport sink   (input valid, input action, input tx_byte, input snapshot_valid,
                    input out_seconds, input out_minutes, input out_hours,
                    input out_weekday, input out_date, input out_month, input out_year,
                    output ready);
endinterface

[hw/rtl/rtcs_cfg_if.sv]
// ----------------------------------------------------------------------------
// rtcs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtcs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rtcs_pkg::CFG_IDX_W-1:0]   index;
    rtcs_pkg::t_byte                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/i2c_rtc_write_then_poll_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_rtc_write_then_poll_sequencer
// Master-side sequencer for an I2C clock chip: one status event in, one
// bus action out.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd  - one transfer per bus controller status event (opcode 0) or per
//            reload (opcode 1, reloads time bytes from the set registers and
//            restarts the write pass).
//   o_res  - one transfer per command: action, tx byte, snapshot flag and the
//            seven held time bytes as they stand after that command.
//   i_cfg  - set register writes (index 0..6, seconds..year); index 7 is
//            ignored. Always ready; write only while no command is in flight.
// The result is registered, valid in the cycle after the command transfer.
// Throughput is one command per cycle while results are taken: the state
// update and result register load happen in the command transfer's cycle.
// The result register is the only buffer: while a result waits on a stalled
// receiver, i_cmd.ready stays low; it rises again in the cycle the result
// is taken, so a new command can transfer in that same cycle.
// Reset (synchronous, active low) loads the set registers and time bytes
// with their defaults, clears the byte index and arms the write pass.
// ----------------------------------------------------------------------------
module i2c_rtc_write_then_poll_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtcs_cmd_if.sink   i_cmd,
    rtcs_res_if.source o_res,
    rtcs_cfg_if.sink   i_cfg
);

    rtcs_pkg::t_byte                r_set  [rtcs_pkg::NUM_TIME];
    rtcs_pkg::t_byte                r_time [rtcs_pkg::NUM_TIME];
    rtcs_pkg::t_byte                n_time [rtcs_pkg::NUM_TIME];
    logic [rtcs_pkg::IDX_W-1:0]     r_byte_index, n_byte_index;
    logic                           r_write_pending, n_write_pending;
    logic                           r_read_direction, n_read_direction;

    logic                           r_res_valid;
    rtcs_pkg::t_action              r_action, n_action;
    rtcs_pkg::t_byte                r_tx_byte, n_tx_byte;
    logic                           r_snap, n_snap;

    logic                           cmd_xfer;
    logic                           res_xfer;

    assign res_xfer    = r_res_valid && o_res.ready;
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    // set registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rtcs_pkg::NUM_TIME; k++) begin
                r_set[k] <= rtcs_pkg::SET_RESET[k];
            end
        end else if (i_cfg.valid && (int'(i_cfg.index) < rtcs_pkg::NUM_TIME)) begin
            r_set[i_cfg.index] <= i_cfg.data;
        end
    end

    // next state and result for the incoming command
    always_comb begin
        for (int k = 0; k < rtcs_pkg::NUM_TIME; k++) begin
            n_time[k] = r_time[k];
        end
        n_byte_index     = r_byte_index;
        n_write_pending  = r_write_pending;
        n_read_direction = r_read_direction;
        n_action         = rtcs_pkg::ACT_NONE;
        n_tx_byte        = '0;
        n_snap           = 1'b0;

        if (i_cmd.opcode == rtcs_pkg::OP_RELOAD) begin
            for (int k = 0; k < rtcs_pkg::NUM_TIME; k++) begin
                n_time[k] = r_set[k];
            end
            n_byte_index     = '0;
            n_write_pending  = 1'b1;
            n_read_direction = 1'b0;
            n_action         = rtcs_pkg::ACT_STOP_START;
        end else begin
            case (i_cmd.status_code)
                rtcs_pkg::ST_START, rtcs_pkg::ST_RSTART: begin
                    n_action  = rtcs_pkg::ACT_SEND;
                    n_tx_byte = rtcs_pkg::DEV_ADDR | {7'd0, r_read_direction};
                end
                rtcs_pkg::ST_SLA_W_ACK: begin
                    n_action  = rtcs_pkg::ACT_SEND;
                    n_tx_byte = rtcs_pkg::PTR_BYTE;
                end
                rtcs_pkg::ST_DATA_ACK: begin
                    if (r_write_pending) begin
                        if (r_byte_index < rtcs_pkg::IDX_CTRL) begin
                            n_action  = rtcs_pkg::ACT_SEND;
                            n_tx_byte = r_time[r_byte_index[2:0]];
                        end else if (r_byte_index == rtcs_pkg::IDX_CTRL) begin
                            n_action  = rtcs_pkg::ACT_SEND;
                            n_tx_byte = rtcs_pkg::CTRL_BYTE;
                        end else if (r_byte_index == rtcs_pkg::IDX_STOP) begin
                            n_action        = rtcs_pkg::ACT_STOP_START;
                            n_write_pending = 1'b0;
                        end
                        n_byte_index = r_byte_index + 4'd1;
                    end else begin
                        n_read_direction = 1'b1;
                        n_action         = rtcs_pkg::ACT_RESTART;
                    end
                end
                rtcs_pkg::ST_SLA_W_NACK, rtcs_pkg::ST_DATA_NACK,
                rtcs_pkg::ST_SLA_R_NACK: begin
                    n_action     = rtcs_pkg::ACT_STOP_START;
                    n_byte_index = '0;
                end
                rtcs_pkg::ST_SLA_R_ACK: begin
                    n_action     = rtcs_pkg::ACT_RX_ACK;
                    n_byte_index = '0;
                end
                rtcs_pkg::ST_RX_ACK: begin
                    if (r_byte_index < rtcs_pkg::IDX_LAST_RX) begin
                        n_time[r_byte_index[2:0]] = i_cmd.rx_byte;
                        n_action                  = rtcs_pkg::ACT_RX_ACK;
                    end else if (r_byte_index == rtcs_pkg::IDX_LAST_RX) begin
                        n_time[r_byte_index[2:0]] = i_cmd.rx_byte;
                        n_action                  = rtcs_pkg::ACT_RX_NACK;
                    end
                    n_byte_index = r_byte_index + 4'd1;
                end
                rtcs_pkg::ST_RX_NACK: begin
                    n_time[rtcs_pkg::TIME_YEAR] = i_cmd.rx_byte;
                    n_snap           = 1'b1;
                    n_action         = rtcs_pkg::ACT_STOP_START;
                    n_byte_index     = '0;
                    n_read_direction = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rtcs_pkg::NUM_TIME; k++) begin
                r_time[k] <= rtcs_pkg::SET_RESET[k];
            end
            r_byte_index     <= '0;
            r_write_pending  <= 1'b1;
            r_read_direction <= 1'b0;
        end else if (cmd_xfer) begin
            for (int k = 0; k < rtcs_pkg::NUM_TIME; k++) begin
                r_time[k] <= n_time[k];
            end
            r_byte_index     <= n_byte_index;
            r_write_pending  <= n_write_pending;
            r_read_direction <= n_read_direction;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (cmd_xfer) begin
            r_res_valid <= 1'b1;
        end else if (res_xfer) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_action  <= n_action;
            r_tx_byte <= n_tx_byte;
            r_snap    <= n_snap;
        end
    end

    // time bytes only change on a command transfer, which needs the result
    // slot free, so they always match the result on display
    assign o_res.valid          = r_res_valid;
    assign o_res.action         = r_action;
    assign o_res.tx_byte        = r_tx_byte;
    assign o_res.snapshot_valid = r_snap;
    assign o_res.out_seconds    = r_time[0];
    assign o_res.out_minutes    = r_time[1];
    assign o_res.out_hours      = r_time[2];
    assign o_res.out_weekday    = r_time[3];
    assign o_res.out_date       = r_time[4];
    assign o_res.out_month      = r_time[5];
    assign o_res.out_year       = r_time[6];

    a_snap_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_snap) |-> (r_action == rtcs_pkg::ACT_STOP_START))
        else $error("snapshot without stop-then-start");

    a_tx_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_action != rtcs_pkg::ACT_SEND)) |-> (r_tx_byte == '0))
        else $error("tx byte set on a non-send action");

    a_write_reads_addr_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_pending |-> !r_read_direction)
        else $error("read direction set during write pass");

    a_reload_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_xfer && (i_cmd.opcode == rtcs_pkg::OP_RELOAD))
        |=> (r_write_pending && (r_byte_index == '0) && r_res_valid))
        else $error("reload did not arm the write pass");

endmodule
